// ===== sv/wrsi_pkg.sv =====
// Shared types and constants of the Wilder RSI unit.
// Used by the divider and the top level; depends on nothing else.
`default_nettype none

package wrsi_pkg;

   localparam int PRICE_W      = 32;
   localparam int PERIOD_W     = 11;
   localparam int RSI_W        = 23;
   localparam int OUT_FRACTION = 16;
   // bits of the integer part of the RSI scale (100 < 2**SCALE_W)
   localparam int SCALE_W      = RSI_W - OUT_FRACTION;
   localparam int RSP_DATA_W   = ((RSI_W + 7) / 8) * 8;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
   localparam logic [RSI_W-1:0]    RSI_FIFTY    = RSI_W'(50 << OUT_FRACTION);
   localparam logic [RSI_W-1:0]    RSI_HUNDRED  = RSI_W'(100 << OUT_FRACTION);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== sv/wrsi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// The dividend shifts out MSB first; uses wrsi_pkg for the status struct.
`default_nettype none

module wrsi_div #(
   parameter int NUM_W = 58,
   parameter int DEN_W = 59
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [$clog2(NUM_W+1)-1:0]   steps,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             rem_init,
   input  logic [DEN_W-1:0]             den,
   output wrsi_pkg::div_status_type     status,
   output logic [NUM_W-1:0]             quot,
   output logic [DEN_W-1:0]             rem
);
   import wrsi_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_diff;
   logic              fits;

   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign fits       = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = num;
         quot_in = '0;
         rem_in  = rem_init;
         den_in  = den;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;
   assign rem         = rem_ff;

endmodule

`default_nettype wire

// ===== sv/wilder_rsi_indicator_unit.sv =====
// Wilder RSI unit: takes one price per beat and returns one Q7.16 RSI per beat,
// with a flag that is 0 during warm-up. One sample is worked on at a time. A warm-up
// sample passes the accept, move and emit steps; a sample that forms or smooths the
// averages goes through the one shared radix-2 divider, which runs gain, loss and
// the final ratio in turn, one quotient bit per cycle. When both averages are zero
// the ratio division is skipped. A stalled output register holds the sample in emit.
// A new sample is taken while the last result still waits in the output register.
// The user must write the period register only while the unit idles; the unit
// itself does not enforce this.
`default_nettype none

module wilder_rsi_indicator_unit #(
   parameter int PERIOD_MAX    = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // period register
   input  logic                               csr_we,
   input  logic [wrsi_pkg::PERIOD_W-1:0]      csr_wdata,
   // sample channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wrsi_pkg::PRICE_W-1:0]       req_tdata,  // [31:0] price
   input  logic [0:0]                         req_tuser,  // [0] series_start
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wrsi_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [22:0] rsi_value, [23] zero
   output logic [0:0]                         rsp_tuser   // [0] rsi_valid
);
   import wrsi_pkg::*;

   localparam int SUM_W  = PRICE_W + $clog2(PERIOD_MAX);
   localparam int ACC_W  = SUM_W + FRACTION_BITS;
   localparam int DEN_W  = ACC_W + 1;
   localparam int STEP_W = $clog2(ACC_W + 1);
   localparam int CNT_W  = $clog2(PERIOD_MAX + 1);
   localparam int HG_W   = ACC_W + SCALE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RSI_PREP,
      ST_RSI_START,
      ST_RSI_WAIT,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic                start_ff, start_in;
   logic [PRICE_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                averaged_ff, averaged_in;
   logic [ACC_W-1:0]    gain_acc_ff, gain_acc_in;
   logic [ACC_W-1:0]    loss_acc_ff, loss_acc_in;
   logic [PRICE_W-1:0]  move_g_ff, move_g_in;
   logic [PRICE_W-1:0]  move_l_ff, move_l_in;
   logic                side_ff, side_in;
   logic [DEN_W-1:0]    sum_ff, sum_in;
   logic [HG_W-1:0]     hg_ff, hg_in;
   logic [RSI_W-1:0]    res_value_ff, res_value_in;
   logic                res_flag_ff, res_flag_in;
   logic                out_valid_ff, out_valid_in;
   logic [RSI_W-1:0]    out_value_ff, out_value_in;
   logic                out_flag_ff, out_flag_in;

   logic [PERIOD_W-1:0] eff_p;
   logic [PRICE_W-1:0]  gain_mv, loss_mv;
   logic                count_reached;
   logic [ACC_W-1:0]    acc_sel, m_ext, diff, form_num, new_avg;
   logic [PRICE_W-1:0]  mv_sel;
   logic                up;

   logic                div_start;
   logic [STEP_W-1:0]   div_steps;
   logic [ACC_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_rem_init, div_den;
   div_status_type      div_st;
   logic [ACC_W-1:0]    div_quot;
   logic [DEN_W-1:0]    div_rem;

   wrsi_div #(
      .NUM_W (ACC_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .num      (div_num),
      .rem_init (div_rem_init),
      .den      (div_den),
      .status   (div_st),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // clamp the period to 1..PERIOD_MAX
   always_comb begin
      if (period_ff == '0) begin
         eff_p = PERIOD_W'(1);
      end else if (int'(period_ff) > PERIOD_MAX) begin
         eff_p = PERIOD_W'(PERIOD_MAX);
      end else begin
         eff_p = period_ff;
      end
   end

   assign gain_mv       = (price_ff > last_ff) ? price_ff - last_ff : '0;
   assign loss_mv       = (price_ff > last_ff) ? '0 : last_ff - price_ff;
   assign count_reached = int'(count_ff) >= int'(eff_p);

   assign acc_sel  = side_ff ? loss_acc_ff : gain_acc_ff;
   assign mv_sel   = side_ff ? move_l_ff : move_g_ff;
   assign m_ext    = ACC_W'({mv_sel, {FRACTION_BITS{1'b0}}});
   assign up       = m_ext >= acc_sel;
   assign diff     = up ? m_ext - acc_sel : acc_sel - m_ext;
   assign form_num = {acc_sel[SUM_W-1:0], {FRACTION_BITS{1'b0}}};

   // smoothing rounds the downward step up so the result stays a floor
   always_comb begin
      if (!averaged_ff) begin
         new_avg = div_quot;
      end else if (up) begin
         new_avg = acc_sel + div_quot;
      end else begin
         new_avg = acc_sel - div_quot - ACC_W'(div_rem != '0);
      end
   end

   always_comb begin
      div_start    = 1'b0;
      div_steps    = '0;
      div_num      = '0;
      div_rem_init = '0;
      div_den      = '0;
      unique case (state_ff)
         ST_DIV_START: begin
            div_start = 1'b1;
            div_steps = STEP_W'(ACC_W);
            div_num   = averaged_ff ? diff : form_num;
            div_den   = DEN_W'(eff_p);
         end
         ST_RSI_START: begin
            // the integer part of 100*gain already sits below the sum, so only
            // the RSI_W quotient bits are left to develop
            div_start    = sum_ff != '0;
            div_steps    = STEP_W'(RSI_W);
            div_num      = {hg_ff[SCALE_W-1:0], {(ACC_W-SCALE_W){1'b0}}};
            div_rem_init = DEN_W'(hg_ff[HG_W-1:SCALE_W]);
            div_den      = sum_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      period_in    = csr_we ? csr_wdata : period_ff;
      price_in     = price_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      averaged_in  = averaged_ff;
      gain_acc_in  = gain_acc_ff;
      loss_acc_in  = loss_acc_ff;
      move_g_in    = move_g_ff;
      move_l_in    = move_l_ff;
      side_in      = side_ff;
      sum_in       = sum_ff;
      hg_in        = hg_ff;
      res_value_in = res_value_ff;
      res_flag_in  = res_flag_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_flag_in  = out_flag_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               price_in = req_tdata;
               start_in = req_tuser[0];
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            last_in = price_ff;
            if (start_ff || (!averaged_ff && count_ff == '0)) begin
               count_in     = CNT_W'(1);
               gain_acc_in  = '0;
               loss_acc_in  = '0;
               averaged_in  = 1'b0;
               res_value_in = '0;
               res_flag_in  = 1'b0;
               state_in     = ST_EMIT;
            end else begin
               move_g_in = gain_mv;
               move_l_in = loss_mv;
               side_in   = 1'b0;
               if (averaged_ff) begin
                  state_in = ST_DIV_START;
               end else begin
                  gain_acc_in = gain_acc_ff + ACC_W'(gain_mv);
                  loss_acc_in = loss_acc_ff + ACC_W'(loss_mv);
                  if (count_reached) begin
                     state_in = ST_DIV_START;
                  end else begin
                     if (int'(count_ff) < PERIOD_MAX) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     res_value_in = '0;
                     res_flag_in  = 1'b0;
                     state_in     = ST_EMIT;
                  end
               end
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_st.done) begin
               if (side_ff) begin
                  loss_acc_in = new_avg;
                  averaged_in = 1'b1;
                  state_in    = ST_RSI_PREP;
               end else begin
                  gain_acc_in = new_avg;
                  side_in     = 1'b1;
                  state_in    = ST_DIV_START;
               end
            end
         end
         ST_RSI_PREP: begin
            sum_in   = DEN_W'(gain_acc_ff) + DEN_W'(loss_acc_ff);
            // 100*gain as 64g + 32g + 4g
            hg_in    = HG_W'({gain_acc_ff, 6'b0}) + HG_W'({gain_acc_ff, 5'b0})
                     + HG_W'({gain_acc_ff, 2'b0});
            state_in = ST_RSI_START;
         end
         ST_RSI_START: begin
            if (sum_ff == '0) begin
               res_value_in = RSI_FIFTY;
               res_flag_in  = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_RSI_WAIT;
            end
         end
         ST_RSI_WAIT: begin
            if (div_st.done) begin
               res_value_in = div_quot[RSI_W-1:0];
               res_flag_in  = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_value_in = res_value_ff;
               out_flag_in  = res_flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         count_ff     <= '0;
         averaged_ff  <= 1'b0;
         side_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         averaged_ff  <= averaged_in;
         side_ff      <= side_in;
         out_valid_ff <= out_valid_in;
      end
      price_ff     <= price_in;
      start_ff     <= start_in;
      last_ff      <= last_in;
      gain_acc_ff  <= gain_acc_in;
      loss_acc_ff  <= loss_acc_in;
      move_g_ff    <= move_g_in;
      move_l_ff    <= move_l_in;
      sum_ff       <= sum_in;
      hg_ff        <= hg_in;
      res_value_ff <= res_value_in;
      res_flag_ff  <= res_flag_in;
      out_value_ff <= out_value_in;
      out_flag_ff  <= out_flag_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_value_ff);
   assign rsp_tuser  = out_flag_ff;

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_st.busy)
      else $error("divider busy while taking a sample");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV_WAIT || state_ff == ST_RSI_WAIT))
      else $error("divider finished outside a wait state");

   a_warmup_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("warm-up beat carries a nonzero value");

   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSI_W-1:0] <= RSI_HUNDRED))
      else $error("RSI above 100");

endmodule

`default_nettype wire

// ===== tb/wilder_rsi_indicator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Wilder RSI unit: directed and random price streams,
// with a scoreboard class that predicts every result. Depends on wrsi_pkg and the unit.
module wilder_rsi_indicator_unit_tb;
   import wrsi_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int PERIOD_LIMIT = 1024;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int RAND_TOTAL = 80 * 4 + 100 + 1100 + 150;
   localparam longint PRICE_TOP = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [RSI_W-1:0] value;
      logic             valid;
   } rsi_result_type;

   class rsi_scoreboard_type;
      logic [PERIOD_W-1:0] period_reg;
      logic [PRICE_W-1:0]  prev_price;
      int unsigned         moves_seen;
      logic [63:0]         gain_mean;
      logic [63:0]         loss_mean;
      bit                  formed;
      rsi_result_type      rsi_q[$];
      int                  errors;

      function new();
         period_reg = PERIOD_RESET;
         prev_price = '0;
         moves_seen = 0;
         gain_mean = '0;
         loss_mean = '0;
         formed = 1'b0;
         errors = 0;
      endfunction

      function void set_period(logic [PERIOD_W-1:0] v);
         period_reg = v;
      endfunction

      function logic [63:0] smoothing_len();
         if (period_reg == 0) return 64'd1;
         if (period_reg > PERIOD_LIMIT) return 64'(PERIOD_LIMIT);
         return 64'(period_reg);
      endfunction

      // sum / p with FRAC_BITS fraction bits, truncated
      function logic [63:0] first_average(logic [63:0] sum, logic [63:0] p);
         return (sum << FRAC_BITS) / p;
      endfunction

      function logic [63:0] wilder_step(logic [63:0] avg, logic [63:0] m, logic [63:0] p);
         if (m >= avg) return avg + (m - avg) / p;
         return avg - (avg - m + p - 1) / p;
      endfunction

      function logic [RSI_W-1:0] rsi_ratio(logic [63:0] g, logic [63:0] l);
         logic [127:0] num;
         logic [127:0] den;
         logic [127:0] q;
         den = 128'(g) + 128'(l);
         if (den == 0) return RSI_FIFTY;
         num = 128'(g) * 128'(RSI_HUNDRED);
         q = num / den;
         return q[RSI_W-1:0];
      endfunction

      function void note_sample(logic [PRICE_W-1:0] price, logic start);
         logic [63:0] p;
         logic [63:0] up;
         logic [63:0] down;
         rsi_result_type exp_r;
         p = smoothing_len();
         up = '0;
         down = '0;
         exp_r = '0;
         if (start || (!formed && moves_seen == 0)) begin
            prev_price = price;
            moves_seen = 1;
            gain_mean = '0;
            loss_mean = '0;
            formed = 1'b0;
         end else begin
            if (price > prev_price) up = price - prev_price;
            else down = prev_price - price;
            prev_price = price;
            if (!formed) begin
               gain_mean += up;
               loss_mean += down;
               if (moves_seen >= p) begin
                  gain_mean = first_average(gain_mean, p);
                  loss_mean = first_average(loss_mean, p);
                  formed = 1'b1;
               end else if (moves_seen < PERIOD_LIMIT) begin
                  moves_seen++;
               end
            end else begin
               gain_mean = wilder_step(gain_mean, up << FRAC_BITS, p);
               loss_mean = wilder_step(loss_mean, down << FRAC_BITS, p);
            end
            if (formed) begin
               exp_r.value = rsi_ratio(gain_mean, loss_mean);
               exp_r.valid = 1'b1;
            end
         end
         rsi_q = {rsi_q, exp_r};
      endfunction

      function void check_result(logic [RSI_W-1:0] value, logic valid);
         rsi_result_type exp_r;
         if (rsi_q.size() == 0) begin
            $error("unexpected beat: rsi_value=%0d rsi_valid=%0d", value, valid);
            errors++;
            return;
         end
         exp_r = rsi_q.pop_front();
         if (valid !== exp_r.valid) begin
            $error("rsi_valid: expected %0d, actual %0d", exp_r.valid, valid);
            errors++;
         end
         if (value !== exp_r.value) begin
            $error("rsi_value: expected %0d, actual %0d", exp_r.value, value);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [PERIOD_W-1:0]   csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PRICE_W-1:0]    req_tdata = '0;   // [31:0] price
   logic [0:0]            req_tuser = '0;   // [0] series_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [22:0] rsi_value, [23] zero
   logic [0:0]            rsp_tuser;        // [0] rsi_valid

   rsi_scoreboard_type sb = new();
   int unsigned   cycle_count = 0;
   int            src_idle_pct = 0;
   int            sink_idle_pct = 0;
   int            rand_sent = 0;
   logic [PRICE_W-1:0] walk_price = 32'h0001_0000;

   wilder_rsi_indicator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wilder_rsi_indicator_unit_tb: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[RSI_W-1:0], rsp_tuser[0]);
   end

   // call at a falling edge while the sample channel is idle
   task automatic write_period(input logic [PERIOD_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_period(v);
   endtask

   // starts and returns at a falling edge; valid stays high for a back-to-back beat
   task automatic send_sample(input logic [PRICE_W-1:0] price, input logic start);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= price;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(price, start);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.rsi_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [PRICE_W-1:0] next_price(logic [PRICE_W-1:0] cur);
      longint      next_val;
      longint      step;
      int unsigned pick;
      pick = $urandom_range(99);
      step = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
      if (pick < 70) begin
         next_val = $urandom_range(1) ? longint'(cur) + step : longint'(cur) - step;
         if (next_val < 0) next_val = 0;
         if (next_val > PRICE_TOP) next_val = PRICE_TOP;
         return next_val[PRICE_W-1:0];
      end
      if (pick < 78) return cur;
      if (pick < 90) return $urandom;
      if (pick < 95) return '0;
      return '1;
   endfunction

   // mostly whole series that get past warm-up; some cut short
   task automatic run_phase(input logic [PERIOD_W-1:0] period_value, input int n_items,
                            input bit fresh);
      int   eff;
      int   left;
      logic start;
      logic [PRICE_W-1:0] price;
      write_period(period_value);
      eff = (period_value == 0) ? 1 :
            (period_value > PERIOD_LIMIT) ? PERIOD_LIMIT : int'(period_value);
      // carry the running series over the period change unless told otherwise
      left = fresh ? 0 : $urandom_range(0, eff);
      for (int i = 0; i < n_items; i++) begin
         start = 1'b0;
         if (left == 0) begin
            start = 1'b1;
            if (eff < 64 && $urandom_range(9) == 0) left = $urandom_range(1, eff);
            else left = eff + $urandom_range(1, 2 * eff + 20);
         end
         left--;
         price = next_price(walk_price);
         walk_price = price;
         if (rand_sent < RAND_TOTAL / 3) begin
            src_idle_pct = 8;
            sink_idle_pct = 81;
         end else if (rand_sent < 2 * RAND_TOTAL / 3) begin
            src_idle_pct = 81;
            sink_idle_pct = 8;
         end else begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
         end
         send_sample(price, start);
         rand_sent++;
      end
      settle();
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // short period: first sample after reset without a start flag, price extremes,
      // zero moves, flat series (both averages zero), and a series left in warm-up
      write_period(11'd2);
      send_sample(32'h1234_5678, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'd7, 1'b1);
      send_sample(32'd7, 1'b0);
      send_sample(32'd7, 1'b0);
      send_sample(32'd7, 1'b0);
      send_sample(32'd3, 1'b1);
      send_sample(32'd4, 1'b0);
      settle();

      // period zero acts as one; it also lands in the middle of warm-up
      write_period(11'd0);
      send_sample(32'd9, 1'b0);
      send_sample(32'd9, 1'b0);
      send_sample(32'd1, 1'b0);
      send_sample(32'd0, 1'b1);
      send_sample(32'd0, 1'b0);
      send_sample(32'd10, 1'b0);
      settle();

      // oversized period clamps while smoothing
      write_period(11'h7FF);
      send_sample(32'd5, 1'b0);
      send_sample(32'd20, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      settle();

      run_phase(PERIOD_RESET, 80, 1'b0);
      run_phase(11'd1, 80, 1'b0);
      run_phase(11'd2, 80, 1'b0);
      run_phase(PERIOD_W'($urandom_range(3, 40)), 100, 1'b0);
      run_phase(11'h7FF, 80, 1'b0);
      run_phase(11'(PERIOD_LIMIT), 1100, 1'b1);
      run_phase(PERIOD_W'($urandom_range(41, 300)), 150, 1'b0);

      repeat (20) @(negedge clock);
      if (sb.errors == 0) begin
         $display("wilder_rsi_indicator_unit_tb: clean");
      end else begin
         $display("wilder_rsi_indicator_unit_tb: errors");
      end
      $finish;
   end

endmodule
